[src/polar_pid_position_controller_assert.svh]
// Assertion macros for the polar PID position controller.
`ifndef POLAR_PID_POSITION_CONTROLLER_ASSERT_SVH
`define POLAR_PID_POSITION_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define PPC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/ppc_pkg.sv]
`default_nettype none
package ppc_pkg;

   localparam int unsigned CORDIC_STEPS_DEF   = 16;
   localparam int unsigned REF_HOLD_TICKS_DEF = 150;

   localparam int XY_W    = 52;
   localparam int Z_W     = 35;
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int DVD_W   = 47;
   localparam int REM_W   = 34;
   localparam int ACC_W   = 50;
   localparam int M_W     = 24;
   localparam int DIV_STEPS = DVD_W;

   localparam int N_GAINS   = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_VEL_P   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_I   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_D   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_P = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_I = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_D = 3'd5;

   localparam logic signed [Z_W-1:0]   PI_Q30       = 35'sd3373259426;
   localparam logic signed [Z_W-1:0]   HALF_PI_Q30  = 35'sd1686629713;
   localparam logic signed [Z_W-1:0]   NEG_HALF_PI  = -35'sd1686629713;
   localparam logic signed [Z_W-1:0]   NEG_PI_Q30   = -35'sd3373259426;
   localparam logic signed [Z_W-1:0]   TWO_PI_Q30   = 35'sd6746518852;
   localparam logic signed [XY_W-1:0]  GAIN_Q30     = 52'sd652032874;
   localparam logic signed [MUL_W-1:0] GAIN_Q28     = 33'sd163008219;
   localparam logic signed [ACC_W-1:0] VEL_LIMIT    = 50'sd26214;
   localparam logic signed [ACC_W-1:0] FORCE_LIMIT  = 50'sd6553600;

   typedef struct packed {
      logic               operation;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] goal_x;
      logic signed [31:0] goal_y;
      logic signed [31:0] heading;
      logic [30:0]        step_time;
      logic [31:0]        time_now;
      logic [31:0]        goal_x_time;
      logic [31:0]        goal_y_time;
      logic               velocity_mode;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive_u;
      logic signed [31:0] drive_v;
      logic               is_velocity;
   } rsp_type;

   function automatic logic [29:0] atan_q30(input logic [4:0] k);
      logic [29:0] r;
      unique case (k)
         5'd0:  r = 30'd843314857;
         5'd1:  r = 30'd497837829;
         5'd2:  r = 30'd263043837;
         5'd3:  r = 30'd133525159;
         5'd4:  r = 30'd67021687;
         5'd5:  r = 30'd33543516;
         5'd6:  r = 30'd16775851;
         5'd7:  r = 30'd8388437;
         5'd8:  r = 30'd4194283;
         5'd9:  r = 30'd2097149;
         5'd31: r = 30'd0;
         default: r = 30'd1 << (5'd30 - k);
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[src/polar_pid_position_controller.sv]
`default_nettype none
// Channel   Ports                              Moves
// request   req_valid/req_ready/req_data       one step or restart word
// response  rsp_valid/rsp_ready/rsp_data       one drive word per control step
// config    csr_we/csr_index/csr_wdata         gain write, no wait
//
// When step_time is zero the division is skipped. Both CORDIC passes share one CORDIC
// step; the 47-step restoring division has its own step logic, and the reciprocal-multiply
// angle wrap and nine products share one multiplier.
// Reset is synchronous and clears gains, integral and last distance.
// A finished word waits in the output register; the next request is taken meanwhile.
// A step stalls in its last cycle while the previous word is still unaccepted.
module polar_pid_position_controller #(
   parameter int unsigned CORDIC_STEPS   = ppc_pkg::CORDIC_STEPS_DEF,
   parameter int unsigned REF_HOLD_TICKS = ppc_pkg::REF_HOLD_TICKS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ppc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ppc_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [ppc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);
   import ppc_pkg::*;

   localparam int CNT_W = $clog2(((CORDIC_STEPS > DIV_STEPS) ? CORDIC_STEPS : DIV_STEPS));
   localparam logic signed [PROD_W-1:0] RND16 = 66'sd32768;
   localparam logic signed [PROD_W-1:0] RND28 = 66'sd134217728;
   localparam logic signed [PROD_W-1:0] RND30 = 66'sd536870912;
   localparam logic signed [XY_W-1:0]   RNDX  = 52'sd32768;
   // floor(2^17 / 2pi), quotient estimate is low by at most one
   localparam logic signed [MUL_W-1:0]  RECIP_2PI = 33'sd20860;
   localparam logic [DVD_W-1:0]         TWO_PI_W  = DVD_W'(TWO_PI_Q30);

   typedef enum logic [3:0] {
      S_IDLE, S_VEC, S_MAG, S_MWAIT, S_MDONE, S_DIV, S_DIVDONE,
      S_WRAP, S_WEND, S_ROTINIT, S_ROT, S_ROTEND, S_OUT
   } state_type;

   typedef enum logic [3:0] {
      MOP_MAG, MOP_INT, MOP_WQ, MOP_WR, MOP_P, MOP_I, MOP_D, MOP_U, MOP_V
   } mop_type;

   state_type               state_ff;
   mop_type                 mop_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    vec_ff;
   logic signed [XY_W-1:0]  x_ff, y_ff;
   logic signed [Z_W-1:0]   z_ff, course_ff;
   req_type                 item_ff;
   logic                    zero_ff, fresh_ff, neg_ff;
   logic [31:0]             mag_ff;
   logic signed [31:0]      last_ff, integ_ff, de_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [M_W-1:0]   m_ff;
   logic signed [MUL_W-1:0] mul_a_ff, mul_b_ff, spc_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [DVD_W-1:0]        dvd_ff;
   logic [REM_W-1:0]        rem_ff;
   logic [MUL_W-1:0]        dvs_ff;
   logic                    dneg_ff;
   logic signed [31:0]      gain_ff [N_GAINS];
   rsp_type                 res_ff, rsp_ff;
   logic                    rsp_valid_ff;

   // request side
   logic signed [32:0]     exs_c, eys_c;
   logic signed [XY_W-1:0] xw_c, yw_c;
   logic [31:0]            hold_c, d1_c, b1_c, d2_c, b2_c;
   logic                   fresh_c;

   assign exs_c  = {req_data.goal_x[31], req_data.goal_x} - {req_data.pos_x[31], req_data.pos_x};
   assign eys_c  = {req_data.goal_y[31], req_data.goal_y} - {req_data.pos_y[31], req_data.pos_y};
   assign xw_c   = {{3{exs_c[32]}}, exs_c, 16'b0};
   assign yw_c   = {{3{eys_c[32]}}, eys_c, 16'b0};
   assign hold_c = 32'(REF_HOLD_TICKS);
   assign d1_c   = req_data.time_now - req_data.goal_x_time;
   assign b1_c   = req_data.goal_x_time - req_data.time_now;
   assign d2_c   = req_data.time_now - req_data.goal_y_time;
   assign b2_c   = req_data.goal_y_time - req_data.time_now;
   assign fresh_c = (d1_c <= hold_c) || (b1_c <= hold_c) ||
                    (d2_c <= hold_c) || (b2_c <= hold_c);

   // shared CORDIC step
   logic [4:0]             k_c;
   logic signed [XY_W-1:0] dx_c, dy_c;
   logic signed [Z_W-1:0]  at_c;
   logic                   p_c, cordic_last_c;

   assign k_c  = cnt_ff[4:0];
   assign dx_c = y_ff >>> k_c;
   assign dy_c = x_ff >>> k_c;
   assign at_c = $signed({5'b0, atan_q30(k_c)});
   assign p_c  = vec_ff ? !y_ff[XY_W-1] : z_ff[Z_W-1];
   assign cordic_last_c = (cnt_ff == CNT_W'(CORDIC_STEPS - 1));

   // restoring divider step
   logic [REM_W-1:0] rem_sh_c;
   logic [REM_W:0]   trial_c;
   logic             qbit_c;

   assign rem_sh_c = {rem_ff[REM_W-2:0], dvd_ff[DVD_W-1]};
   assign trial_c  = {1'b0, rem_sh_c} - {2'b0, dvs_ff};
   assign qbit_c   = !trial_c[REM_W];

   // product rounding and truncation
   logic signed [PROD_W-1:0] p16_c, p28_c, p30_c, f16_c;
   assign p16_c = (prod_ff + RND16) >>> 16;
   assign p28_c = (prod_ff + RND28) >>> 28;
   assign p30_c = (prod_ff + RND30) >>> 30;
   assign f16_c = prod_ff >>> 16;

   // magnitude
   logic signed [XY_W-1:0] tr_c;
   logic [31:0]            t32_c, e_c;
   assign tr_c  = (x_ff + RNDX) >>> 16;
   assign t32_c = (zero_ff || tr_c[XY_W-1]) ? 32'd0 :
                  (|tr_c[XY_W-2:32]) ? 32'hFFFF_FFFF : tr_c[31:0];
   assign e_c   = (|p28_c[PROD_W-1:31]) ? 32'h7FFF_FFFF : p28_c[31:0];

   // integral and derivative
   logic signed [48:0] isum_c;
   logic [31:0]        isat_c;
   logic signed [32:0] diff_c;
   logic [32:0]        dabs_c;
   logic [DVD_W-1:0]   q_c;
   logic [31:0]        de_c;

   assign isum_c = $signed(f16_c[48:0]) + $signed({{17{integ_ff[31]}}, integ_ff});
   assign isat_c = (isum_c[48:31] == {18{isum_c[48]}}) ? isum_c[31:0] :
                   (isum_c[48] ? 32'h8000_0000 : 32'h7FFF_FFFF);
   assign diff_c = $signed({1'b0, mag_ff}) - $signed({last_ff[31], last_ff});
   assign dabs_c = diff_c[32] ? -diff_c : diff_c;
   assign q_c    = dvd_ff;
   assign de_c   = !dneg_ff ? ((|q_c[DVD_W-1:31]) ? 32'h7FFF_FFFF : {1'b0, q_c[30:0]}) :
                   ((|q_c[DVD_W-1:32]) || (q_c[31] && (|q_c[30:0]))) ? 32'h8000_0000 :
                   (32'd0 - q_c[31:0]);

   // heading-relative course
   logic signed [47:0]    v_c;
   logic [47:0]           vabs_c;
   logic signed [Z_W-1:0] r0_c, r_c, zf_c;
   logic                  fneg_c;

   assign v_c    = $signed({{13{course_ff[Z_W-1]}}, course_ff}) -
                   $signed({{2{item_ff.heading[31]}}, item_ff.heading, 14'b0});
   assign vabs_c = v_c[47] ? -v_c : v_c;
   assign r0_c   = (dneg_ff && (dvd_ff != '0)) ?
                   (TWO_PI_Q30 - $signed({1'b0, dvd_ff[REM_W-1:0]})) :
                   $signed({1'b0, dvd_ff[REM_W-1:0]});
   assign r_c    = (r0_c > PI_Q30) ? (r0_c - TWO_PI_Q30) : r0_c;
   assign fneg_c = (course_ff > HALF_PI_Q30) || (course_ff < NEG_HALF_PI);
   assign zf_c   = (course_ff > HALF_PI_Q30) ? (course_ff - PI_Q30) :
                   (course_ff < NEG_HALF_PI) ? (course_ff - NEG_PI_Q30) : course_ff;

   // PID and rotation
   logic signed [31:0]      gp_c, gi_c, gd_c;
   logic signed [ACC_W-1:0] lim_c, nlim_c;
   logic signed [XY_W-1:0]  c_c, s_c, cms_c, spc_c;

   assign gp_c   = item_ff.velocity_mode ? gain_ff[CSR_VEL_P] : gain_ff[CSR_FORCE_P];
   assign gi_c   = item_ff.velocity_mode ? gain_ff[CSR_VEL_I] : gain_ff[CSR_FORCE_I];
   assign gd_c   = item_ff.velocity_mode ? gain_ff[CSR_VEL_D] : gain_ff[CSR_FORCE_D];
   assign lim_c  = item_ff.velocity_mode ? VEL_LIMIT : FORCE_LIMIT;
   assign nlim_c = -lim_c;
   assign c_c    = neg_ff ? -x_ff : x_ff;
   assign s_c    = neg_ff ? -y_ff : y_ff;
   assign cms_c  = c_c - s_c;
   assign spc_c  = s_c + c_c;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mop_ff       <= MOP_MAG;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         last_ff      <= '0;
         for (int i = 0; i < N_GAINS; i++) begin
            gain_ff[i] <= '0;
         end
      end else begin
         prod_ff <= mul_a_ff * mul_b_ff;
         if (csr_we && (csr_index <= CSR_FORCE_D)) begin
            gain_ff[csr_index] <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  item_ff <= req_data;
                  if (req_data.operation) begin
                     integ_ff <= '0;
                  end else begin
                     fresh_ff <= fresh_c;
                     zero_ff  <= (exs_c == '0) && (eys_c == '0);
                     vec_ff   <= 1'b1;
                     cnt_ff   <= '0;
                     if (exs_c[32]) begin
                        if (!eys_c[32]) begin
                           x_ff <= yw_c;
                           y_ff <= -xw_c;
                           z_ff <= HALF_PI_Q30;
                        end else begin
                           x_ff <= -yw_c;
                           y_ff <= xw_c;
                           z_ff <= NEG_HALF_PI;
                        end
                     end else begin
                        x_ff <= xw_c;
                        y_ff <= yw_c;
                        z_ff <= '0;
                     end
                     state_ff <= S_VEC;
                  end
               end
            end
            S_VEC, S_ROT: begin
               x_ff <= p_c ? (x_ff + dx_c) : (x_ff - dx_c);
               y_ff <= p_c ? (y_ff - dy_c) : (y_ff + dy_c);
               z_ff <= p_c ? (z_ff + at_c) : (z_ff - at_c);
               cnt_ff <= cnt_ff + 1'b1;
               if (cordic_last_c) begin
                  state_ff <= (state_ff == S_VEC) ? S_MAG : S_ROTEND;
               end
            end
            S_MAG: begin
               course_ff <= zero_ff ? '0 : z_ff;
               mul_a_ff  <= {1'b0, t32_c};
               mul_b_ff  <= GAIN_Q28;
               mop_ff    <= MOP_MAG;
               state_ff  <= S_MWAIT;
            end
            S_MWAIT: begin
               state_ff <= S_MDONE;
            end
            S_MDONE: begin
               case (mop_ff)
                  MOP_MAG: begin
                     mag_ff   <= e_c;
                     mul_a_ff <= {1'b0, e_c};
                     mul_b_ff <= {2'b0, item_ff.step_time};
                     mop_ff   <= MOP_INT;
                     state_ff <= S_MWAIT;
                  end
                  MOP_INT: begin
                     integ_ff <= fresh_ff ? 32'd0 : isat_c;
                     last_ff  <= mag_ff;
                     rem_ff   <= '0;
                     cnt_ff   <= '0;
                     if (item_ff.step_time == '0) begin
                        de_ff    <= diff_c[32] ? 32'h8000_0000 :
                                    ((diff_c != '0) ? 32'h7FFF_FFFF : 32'd0);
                        mul_a_ff <= {1'b0, vabs_c[45:14]};
                        mul_b_ff <= RECIP_2PI;
                        dneg_ff  <= v_c[47];
                        mop_ff   <= MOP_WQ;
                        state_ff <= S_MWAIT;
                     end else begin
                        dvd_ff   <= {dabs_c[30:0], 16'b0};
                        dvs_ff   <= {2'b0, item_ff.step_time};
                        dneg_ff  <= diff_c[32];
                        state_ff <= S_DIV;
                     end
                  end
                  MOP_WQ: begin
                     mul_a_ff <= {18'b0, prod_ff[46:33], 1'b0};
                     mul_b_ff <= PI_Q30[MUL_W-1:0];
                     mop_ff   <= MOP_WR;
                     state_ff <= S_MWAIT;
                  end
                  MOP_WR: begin
                     dvd_ff   <= vabs_c[DVD_W-1:0] - prod_ff[DVD_W-1:0];
                     cnt_ff   <= '0;
                     state_ff <= S_WRAP;
                  end
                  MOP_P: begin
                     acc_ff   <= p16_c[ACC_W-1:0];
                     mul_a_ff <= {gi_c[31], gi_c};
                     mul_b_ff <= {integ_ff[31], integ_ff};
                     mop_ff   <= MOP_I;
                     state_ff <= S_MWAIT;
                  end
                  MOP_I: begin
                     acc_ff   <= acc_ff + p16_c[ACC_W-1:0];
                     mul_a_ff <= {gd_c[31], gd_c};
                     mul_b_ff <= {de_ff[31], de_ff};
                     mop_ff   <= MOP_D;
                     state_ff <= S_MWAIT;
                  end
                  MOP_D: begin
                     acc_ff   <= acc_ff + p16_c[ACC_W-1:0];
                     state_ff <= S_ROTINIT;
                  end
                  MOP_U: begin
                     res_ff.drive_u <= p30_c[31:0];
                     mul_b_ff       <= spc_ff;
                     mop_ff         <= MOP_V;
                     state_ff       <= S_MWAIT;
                  end
                  MOP_V: begin
                     res_ff.drive_v     <= p30_c[31:0];
                     res_ff.is_velocity <= item_ff.velocity_mode;
                     state_ff           <= S_OUT;
                  end
                  default: begin
                     state_ff <= S_IDLE;
                  end
               endcase
            end
            S_DIV: begin
               rem_ff <= qbit_c ? trial_c[REM_W-1:0] : rem_sh_c;
               dvd_ff <= {dvd_ff[DVD_W-2:0], qbit_c};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= S_DIVDONE;
               end
            end
            S_DIVDONE: begin
               de_ff    <= de_c;
               mul_a_ff <= {1'b0, vabs_c[45:14]};
               mul_b_ff <= RECIP_2PI;
               dneg_ff  <= v_c[47];
               mop_ff   <= MOP_WQ;
               state_ff <= S_MWAIT;
            end
            S_WRAP: begin
               dvd_ff <= (dvd_ff >= TWO_PI_W) ? (dvd_ff - TWO_PI_W) : dvd_ff;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= S_WEND;
               end
            end
            S_WEND: begin
               course_ff <= r_c;
               mul_a_ff  <= {gp_c[31], gp_c};
               mul_b_ff  <= {1'b0, mag_ff};
               mop_ff    <= MOP_P;
               state_ff  <= S_MWAIT;
            end
            S_ROTINIT: begin
               m_ff   <= (acc_ff > lim_c) ? lim_c[M_W-1:0] :
                         (acc_ff < nlim_c) ? nlim_c[M_W-1:0] : acc_ff[M_W-1:0];
               neg_ff <= fneg_c;
               z_ff   <= zf_c;
               x_ff   <= GAIN_Q30;
               y_ff   <= '0;
               vec_ff <= 1'b0;
               cnt_ff <= '0;
               state_ff <= S_ROT;
            end
            S_ROTEND: begin
               mul_a_ff <= {{(MUL_W-M_W){m_ff[M_W-1]}}, m_ff};
               mul_b_ff <= cms_c[MUL_W-1:0];
               spc_ff   <= spc_c[MUL_W-1:0];
               mop_ff   <= MOP_U;
               state_ff <= S_MWAIT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`include "polar_pid_position_controller_assert.svh"

   `PPC_ASSERT_NEXT(a_restart_clears, req_valid && req_ready && req_data.operation, integ_ff == 32'sd0, "restart left integral set")
   `PPC_ASSERT_IMPLY(a_div_bound, state_ff == S_DIV, cnt_ff < CNT_W'(DIV_STEPS), "divider ran past its last step")
   `PPC_ASSERT_IMPLY(a_mag_range, state_ff == S_MDONE && mop_ff == MOP_INT, !mag_ff[31], "distance negative")
   `PPC_ASSERT_IMPLY(a_m_limit, state_ff == S_ROT, m_ff <= $signed(FORCE_LIMIT[M_W-1:0]) && m_ff >= -$signed(FORCE_LIMIT[M_W-1:0]), "PID output beyond limit")

endmodule
`default_nettype wire

[dv/tb_polar_pid_position_controller.sv]
`default_nettype none
module tb_polar_pid_position_controller;
   import ppc_pkg::*;

   localparam int  N_ITER      = 16;
   localparam int  HOLD_TICKS  = 150;
   localparam int  SETTLE      = 220;
   localparam longint LIMIT_CYCLES = 2000000;
   localparam longint HALF_PI  = 64'sd1686629713;
   localparam longint PI_V     = 64'sd3373259426;
   localparam longint TWO_PI   = 64'sd6746518852;
   localparam longint K_Q30    = 652032874;
   localparam longint K_Q28    = 163008219;
   localparam longint VEL_LIM  = 26214;
   localparam longint FORCE_LIM = 6553600;
   localparam longint MAX32    = 64'sd2147483647;
   localparam longint MIN32    = -64'sd2147483648;
   localparam longint ATAN_TAB [0:31] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
      128, 64, 32, 16, 8, 4, 2, 1, 0};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_VEL_P;
   logic [31:0] csr_wdata = '0;

   polar_pid_position_controller i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   longint  gain_copy [0:5];
   longint  integral_acc;
   longint  prev_distance;
   rsp_type drive_queue [$];
   int      errors = 0;
   int      n_steps = 0;
   int      n_restarts = 0;
   int      n_settings = 0;
   bit      quiet = 1'b0;
   longint  cycles = 0;
   int      ready_hold = 0;

   function automatic longint rnd_sh(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic bit ticks_close(logic [31:0] now, logic [31:0] t);
      logic [31:0] fwd, back;
      fwd = now - t;
      back = t - now;
      return fwd <= HOLD_TICKS || back <= HOLD_TICKS;
   endfunction

   function automatic void polar_of(longint ex, longint ey, output longint mag,
                                    output longint ang);
      longint x, y, z, t, dx, dy;
      x = ex * 65536;
      y = ey * 65536;
      z = 0;
      if (ex == 0 && ey == 0) begin
         mag = 0;
         ang = 0;
         return;
      end
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = HALF_PI;
         end else begin
            x = -y; y = t; z = -HALF_PI;
         end
      end
      for (int i = 0; i < N_ITER; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += ATAN_TAB[i];
         end else begin
            x -= dx; y += dy; z -= ATAN_TAB[i];
         end
      end
      t = rnd_sh(x, 16);
      mag = clamp(rnd_sh(t * K_Q28, 28), 0, MAX32);
      ang = z;
   endfunction

   function automatic void cos_sin(longint a, output longint c, output longint s);
      longint x, y, z, dx, dy;
      bit flip;
      x = K_Q30; y = 0; z = a; flip = 1'b0;
      if (z > HALF_PI) begin
         z -= PI_V; flip = 1'b1;
      end else if (z < -HALF_PI) begin
         z += PI_V; flip = 1'b1;
      end
      for (int i = 0; i < N_ITER; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_TAB[i];
         end else begin
            x += dx; y -= dy; z += ATAN_TAB[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   task automatic predict_drive(req_type w);
      longint distance, course, dt, diff, rate, rel, m, lim, c, s, gp, gi, gd;
      rsp_type exp_word;
      if (w.operation) begin
         integral_acc = 0;
         n_restarts++;
         return;
      end
      dt = longint'(w.step_time);
      polar_of(longint'(w.goal_x) - longint'(w.pos_x),
               longint'(w.goal_y) - longint'(w.pos_y), distance, course);
      integral_acc = clamp(integral_acc + ((distance * dt) >>> 16), MIN32, MAX32);
      diff = distance - prev_distance;
      if (dt == 0) rate = diff > 0 ? MAX32 : (diff < 0 ? MIN32 : 0);
      else rate = clamp((diff * 65536) / dt, MIN32, MAX32);
      prev_distance = distance;
      if (ticks_close(w.time_now, w.goal_x_time) || ticks_close(w.time_now, w.goal_y_time))
         integral_acc = 0;
      rel = (course - longint'(w.heading) * 16384) % TWO_PI;
      if (rel < 0) rel += TWO_PI;
      if (rel > PI_V) rel -= TWO_PI;
      gp = w.velocity_mode ? gain_copy[0] : gain_copy[3];
      gi = w.velocity_mode ? gain_copy[1] : gain_copy[4];
      gd = w.velocity_mode ? gain_copy[2] : gain_copy[5];
      m = rnd_sh(gp * distance, 16) + rnd_sh(gi * integral_acc, 16) + rnd_sh(gd * rate, 16);
      lim = w.velocity_mode ? VEL_LIM : FORCE_LIM;
      m = clamp(m, -lim, lim);
      cos_sin(rel, c, s);
      exp_word.drive_u = 32'(clamp(rnd_sh(m * (c - s), 30), MIN32, MAX32));
      exp_word.drive_v = 32'(clamp(rnd_sh(m * (s + c), 30), MIN32, MAX32));
      exp_word.is_velocity = w.velocity_mode;
      drive_queue.push_back(exp_word);
      n_steps++;
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_queue.size() == 0) begin
            $error("drive word with nothing expected");
            errors++;
         end else begin
            want = drive_queue.pop_front();
            if (rsp_data.drive_u !== want.drive_u) begin
               $error("drive_u expected %0d actual %0d", want.drive_u, rsp_data.drive_u);
               errors++;
            end
            if (rsp_data.drive_v !== want.drive_v) begin
               $error("drive_v expected %0d actual %0d", want.drive_v, rsp_data.drive_v);
               errors++;
            end
            if (rsp_data.is_velocity !== want.is_velocity) begin
               $error("is_velocity expected %0d actual %0d", want.is_velocity,
                      rsp_data.is_velocity);
               errors++;
            end
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(5) == 0) begin
         rsp_ready <= 1'b0;
         ready_hold <= $urandom_range(1, 10) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_word(req_type w);
      if (!quiet && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_data <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_drive(w);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (drive_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_gains(longint g0, longint g1, longint g2, longint g3, longint g4,
                             longint g5);
      longint vals [0:5];
      vals = '{g0, g1, g2, g3, g4, g5};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i][31:0];
         gain_copy[i] = longint'(signed'(vals[i][31:0]));
         @(negedge clock);
      end
      csr_we <= 1'b0;
      n_settings++;
   endtask

   function automatic req_type control_word(longint px, longint py, longint gx, longint gy,
                                            longint hd, longint dt, bit vel);
      req_type w;
      w = '0;
      w.pos_x = px[31:0]; w.pos_y = py[31:0];
      w.goal_x = gx[31:0]; w.goal_y = gy[31:0];
      w.heading = hd[31:0];
      w.step_time = dt[30:0];
      w.time_now = 32'd100000;
      w.goal_x_time = 32'd0;
      w.goal_y_time = 32'd0;
      w.velocity_mode = vel;
      return w;
   endfunction

   function automatic logic [31:0] pick32(bit wide);
      if (wide) return $urandom;
      return 32'($signed($urandom_range(0, 2 * 1048576)) - 1048576);
   endfunction

   function automatic req_type random_word();
      req_type w;
      bit wide;
      wide = $urandom_range(4) == 0;
      w.operation = $urandom_range(15) == 0;
      w.pos_x = pick32(wide); w.pos_y = pick32(wide);
      w.goal_x = pick32(wide); w.goal_y = pick32(wide);
      w.heading = $urandom_range(1) ? pick32(1'b0) : pick32(1'b1);
      case ($urandom_range(5))
         0: w.step_time = '0;
         1: w.step_time = 31'($urandom);
         default: w.step_time = 31'($urandom_range(1, 65536));
      endcase
      w.time_now = $urandom;
      w.goal_x_time = $urandom_range(3) == 0 ?
                      w.time_now + 32'($urandom_range(0, 320)) - 32'd160 : $urandom;
      w.goal_y_time = $urandom_range(3) == 0 ?
                      w.time_now + 32'($urandom_range(0, 320)) - 32'd160 : $urandom;
      w.velocity_mode = $urandom_range(1);
      return w;
   endfunction

   function automatic longint random_gain(bit wide);
      if (wide) return longint'($signed($urandom));
      return longint'($signed($urandom_range(0, 262144))) - 131072;
   endfunction

   task automatic test_directed;
      req_type w;
      load_gains(65536, 6554, 3277, 1310720, 65536, 32768);
      send_word(control_word(0, 0, 0, 0, 0, 65536, 1'b1));
      send_word(control_word(0, 0, 65536, 0, 0, 65536, 1'b1));
      send_word(control_word(0, 0, 0, 65536, 0, 0, 1'b0));
      send_word(control_word(0, 0, 0, 65536, 0, 0, 1'b0));
      send_word(control_word(0, 0, 0, 0, 0, 0, 1'b0));
      send_word(control_word(MAX32, MAX32, MIN32, MIN32, MAX32, 31'h7fffffff, 1'b0));
      send_word(control_word(MIN32, MIN32, MAX32, MAX32, MIN32, 1, 1'b1));
      send_word(control_word(MIN32, 0, MAX32, 0, 205887, 65536, 1'b0));
      send_word(control_word(0, 0, -131072, 65536, -205887, 32768, 1'b1));
      send_word(control_word(0, 0, -131072, -65536, 102943, 32768, 1'b0));
      w = control_word(0, 0, 196608, 0, 0, 65536, 1'b0);
      w.goal_x_time = w.time_now - HOLD_TICKS;
      send_word(w);
      w.goal_x_time = w.time_now - HOLD_TICKS - 1;
      send_word(w);
      w.goal_x_time = 32'd0;
      w.goal_y_time = w.time_now + HOLD_TICKS;
      send_word(w);
      w.time_now = 32'd20;
      w.goal_y_time = 32'hffffff90;
      send_word(w);
      w.operation = 1'b1;
      send_word(w);
      w = control_word(65536, 65536, 0, 0, 0, 65536, 1'b1);
      send_word(w);
      drain;
   endtask

   task automatic test_gain_extremes;
      load_gains(MAX32, MAX32, MAX32, MAX32, MAX32, MAX32);
      send_word(control_word(0, 0, MAX32, MAX32, 0, 31'h7fffffff, 1'b1));
      send_word(control_word(0, 0, MIN32, 0, 102943, 0, 1'b0));
      drain;
      load_gains(MIN32, MIN32, MIN32, MIN32, MIN32, MIN32);
      send_word(control_word(0, 0, MAX32, MAX32, 0, 31'h7fffffff, 1'b0));
      send_word(control_word(0, 0, MIN32, 0, -102943, 0, 1'b1));
      drain;
   endtask

   task automatic test_random;
      for (int phase = 0; phase < 8; phase++) begin
         load_gains(random_gain(phase == 3), random_gain(phase == 3), random_gain(phase == 5),
                    random_gain(phase == 5), random_gain(phase == 6), random_gain(phase == 6));
         if (phase == 7) quiet = 1'b1;
         repeat (118) send_word(random_word());
         drain;
      end
   endtask

   initial begin
      for (int i = 0; i < 6; i++) gain_copy[i] = 0;
      integral_acc = 0;
      prev_distance = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed;
      test_gain_extremes;
      test_random;
      $display("Ran %0d control steps and %0d restarts over %0d gain settings,",
               n_steps, n_restarts, n_settings);
      $display("with extreme values, zero step times and fresh references.");
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire

[filelist.f]
+incdir+src
src/ppc_pkg.sv
src/polar_pid_position_controller.sv
dv/tb_polar_pid_position_controller.sv
